### rtl/svec_pkg.sv
// shared constants, codes and types of the sortable integer vector
`timescale 1ns / 1ps

package svec_pkg;

    localparam int DEPTH        = 64;
    localparam int DATA_W       = 32;
    localparam int CNT_W        = $clog2(DEPTH + 1);
    localparam int IDX_W        = $clog2(DEPTH);
    localparam int FIELD_IDX_W  = 6;
    localparam int CMP_W        = (CNT_W > FIELD_IDX_W) ? CNT_W : FIELD_IDX_W;
    localparam int CMD_W        = 3;
    localparam int STATUS_W     = 2;
    localparam int LEN_W        = 7;
    localparam int IN_FIELDS_W  = DATA_W + 2 * FIELD_IDX_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = DATA_W + STATUS_W + LEN_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP_BACK   = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_SWAP       = 3'd4,
        CMD_SORT       = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_PUT,
        CELL_SHIFT_UP,
        CELL_ROTATE,
        CELL_SORT,
        CELL_SWAP
    } cell_op_t;

    typedef struct packed {
        cell_op_t              op;
        logic                  phase;
        logic [CNT_W-1:0]      count;
        logic [CNT_W-1:0]      pos_a;
        logic [CNT_W-1:0]      pos_b;
        logic [DATA_W-1:0]     value;
        logic [DATA_W-1:0]     data_a;
        logic [DATA_W-1:0]     data_b;
    } cell_ctrl_t;

endpackage

### rtl/svec_cell.sv
// one storage cell of the row: holds one entry, writes, shifts, rotates, swaps and compare-exchanges
`timescale 1ns / 1ps

module svec_cell (
    input  logic                                clk,
    input  svec_pkg::cell_ctrl_t                ctrl,
    input  logic [svec_pkg::IDX_W-1:0]          idx,
    input  logic [svec_pkg::DATA_W-1:0]         left,
    input  logic [svec_pkg::DATA_W-1:0]         right,
    output logic [svec_pkg::DATA_W-1:0]         entry
);
    import svec_pkg::*;

    logic [DATA_W-1:0] entry_reg;
    logic [DATA_W-1:0] entry_next;
    logic [CNT_W-1:0]  pos;
    logic              lower;
    logic              pair_r;
    logic              pair_l;

    always_comb
    begin
        pos    = CNT_W'(idx);
        // odd-even transposition: lower partner pairs with its right neighbor
        lower  = (idx[0] == ctrl.phase);
        pair_r = lower && ((pos + CNT_W'(1)) < ctrl.count);
        pair_l = !lower && (idx != '0) && (pos < ctrl.count);
        entry_next = entry_reg;
        case (ctrl.op)
            CELL_PUT:
            begin
                if (pos == ctrl.pos_a)
                    entry_next = ctrl.value;
            end
            CELL_SHIFT_UP:
                entry_next = left;
            CELL_ROTATE:
                entry_next = right;
            CELL_SORT:
            begin
                if (pair_r && ($signed(right) < $signed(entry_reg)))
                    entry_next = right;
                else if (pair_l && ($signed(left) > $signed(entry_reg)))
                    entry_next = left;
            end
            CELL_SWAP:
            begin
                if (pos == ctrl.pos_a)
                    entry_next = ctrl.data_b;
                else if (pos == ctrl.pos_b)
                    entry_next = ctrl.data_a;
            end
            default:
                entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

### rtl/svec_ctrl.sv
// command sequencer, count keeper and result buffering for the cell row
`timescale 1ns / 1ps

module svec_ctrl (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [svec_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic [svec_pkg::CMD_W-1:0]          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [svec_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic [svec_pkg::DATA_W-1:0]         head,
    output svec_pkg::cell_ctrl_t                cctl
);
    import svec_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROT,
        S_SWAP,
        S_SORT
    } state_t;

    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(DEPTH - 1);
    localparam int OUT_PAD = OUT_TDATA_W - OUT_FIELDS_W;

    state_t                state_reg, state_next;
    cmd_t                  cmd_reg, cmd_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [IDX_W-1:0]      step_reg, step_next;
    logic [CNT_W-1:0]      pos_a_reg, pos_a_next;
    logic [CNT_W-1:0]      pos_b_reg, pos_b_next;
    logic [DATA_W-1:0]     data_a_reg, data_a_next;
    logic [DATA_W-1:0]     data_b_reg, data_b_next;
    logic                  fin_valid_reg, fin_valid_next;
    logic [DATA_W-1:0]     fin_popped_reg, fin_popped_next;
    logic [STATUS_W-1:0]   fin_status_reg, fin_status_next;
    logic [LEN_W-1:0]      fin_length_reg, fin_length_next;
    logic                  out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]     out_popped_reg, out_popped_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;
    logic [LEN_W-1:0]      out_length_reg, out_length_next;

    logic                  in_fire;
    logic                  fin_move;
    logic                  finish;
    logic [DATA_W-1:0]     pop_v;
    logic [STATUS_W-1:0]   stat_v;
    logic [DATA_W-1:0]     in_value;
    logic [FIELD_IDX_W-1:0] in_ia;
    logic [FIELD_IDX_W-1:0] in_ib;
    logic                  at_a;
    logic                  at_b;
    logic                  full;
    logic                  empty;

    assign in_value = s_tdata[DATA_W-1:0];
    assign in_ia    = s_tdata[DATA_W +: FIELD_IDX_W];
    assign in_ib    = s_tdata[DATA_W + FIELD_IDX_W +: FIELD_IDX_W];
    assign s_tready = (state_reg == S_IDLE) && !fin_valid_reg;
    assign in_fire  = s_tvalid && s_tready;
    assign fin_move = fin_valid_reg && (!out_valid_reg || m_tready);
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign at_a     = (CNT_W'(step_reg) == pos_a_reg);
    assign at_b     = (CNT_W'(step_reg) == pos_b_reg);

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        count_next      = count_reg;
        step_next       = step_reg;
        pos_a_next      = pos_a_reg;
        pos_b_next      = pos_b_reg;
        data_a_next     = data_a_reg;
        data_b_next     = data_b_reg;
        fin_valid_next  = fin_valid_reg;
        fin_popped_next = fin_popped_reg;
        fin_status_next = fin_status_reg;
        fin_length_next = fin_length_reg;
        out_valid_next  = out_valid_reg;
        out_popped_next = out_popped_reg;
        out_status_next = out_status_reg;
        out_length_next = out_length_reg;
        finish          = 1'b0;
        pop_v           = '0;
        stat_v          = ST_OK;

        cctl.op     = CELL_HOLD;
        cctl.phase  = step_reg[0];
        cctl.count  = count_reg;
        cctl.pos_a  = (state_reg == S_SWAP) ? pos_a_reg : count_reg;
        cctl.pos_b  = pos_b_reg;
        cctl.value  = in_value;
        cctl.data_a = data_a_reg;
        cctl.data_b = data_b_reg;

        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;
        if (fin_move)
        begin
            out_valid_next  = 1'b1;
            out_popped_next = fin_popped_reg;
            out_status_next = fin_status_reg;
            out_length_next = fin_length_reg;
            fin_valid_next  = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd_next  = cmd_t'(s_tuser);
                    step_next = '0;
                    case (cmd_t'(s_tuser))
                        CMD_PUSH_BACK,
                        CMD_PUSH_FRONT:
                        begin
                            finish = 1'b1;
                            if (full)
                                stat_v = ST_FULL;
                            else
                            begin
                                cctl.op    = (cmd_t'(s_tuser) == CMD_PUSH_BACK) ?
                                             CELL_PUT : CELL_SHIFT_UP;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_POP_BACK:
                        begin
                            if (empty)
                            begin
                                finish = 1'b1;
                                stat_v = ST_EMPTY;
                            end
                            else
                            begin
                                pos_a_next = count_reg - CNT_W'(1);
                                pos_b_next = count_reg - CNT_W'(1);
                                state_next = S_ROT;
                            end
                        end
                        CMD_POP_FRONT:
                        begin
                            finish = 1'b1;
                            if (empty)
                                stat_v = ST_EMPTY;
                            else
                            begin
                                // rotation moves the head into the top cell, past the count
                                cctl.op    = CELL_ROTATE;
                                pop_v      = head;
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        CMD_SWAP:
                        begin
                            if ((CMP_W'(in_ia) >= CMP_W'(count_reg)) ||
                                (CMP_W'(in_ib) >= CMP_W'(count_reg)))
                            begin
                                finish = 1'b1;
                                stat_v = ST_RANGE;
                            end
                            else
                            begin
                                pos_a_next = CNT_W'(in_ia);
                                pos_b_next = CNT_W'(in_ib);
                                state_next = S_ROT;
                            end
                        end
                        CMD_SORT:
                            state_next = S_SORT;
                        default:
                            finish = 1'b1;
                    endcase
                end
            end
            S_ROT:
            begin
                // a full turn of the row brings every entry past cell zero once
                cctl.op   = CELL_ROTATE;
                step_next = step_reg + IDX_W'(1);
                if (at_a)
                    data_a_next = head;
                if (at_b)
                    data_b_next = head;
                if (step_reg == LAST_STEP)
                begin
                    step_next = '0;
                    if (cmd_reg == CMD_POP_BACK)
                    begin
                        finish     = 1'b1;
                        pop_v      = at_a ? head : data_a_reg;
                        count_next = count_reg - CNT_W'(1);
                        state_next = S_IDLE;
                    end
                    else
                        state_next = S_SWAP;
                end
            end
            S_SWAP:
            begin
                cctl.op    = CELL_SWAP;
                finish     = 1'b1;
                state_next = S_IDLE;
            end
            S_SORT:
            begin
                cctl.op   = CELL_SORT;
                step_next = step_reg + IDX_W'(1);
                if (step_reg == LAST_STEP)
                begin
                    step_next  = '0;
                    finish     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase

        // finish only ever happens with the result slot empty
        if (finish)
        begin
            fin_valid_next  = 1'b1;
            fin_popped_next = pop_v;
            fin_status_next = stat_v;
            fin_length_next = LEN_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cmd_reg        <= CMD_PUSH_BACK;
            count_reg      <= '0;
            step_reg       <= '0;
            pos_a_reg      <= '0;
            pos_b_reg      <= '0;
            data_a_reg     <= '0;
            data_b_reg     <= '0;
            fin_valid_reg  <= 1'b0;
            fin_popped_reg <= '0;
            fin_status_reg <= ST_OK;
            fin_length_reg <= '0;
            out_valid_reg  <= 1'b0;
            out_popped_reg <= '0;
            out_status_reg <= ST_OK;
            out_length_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cmd_reg        <= cmd_next;
            count_reg      <= count_next;
            step_reg       <= step_next;
            pos_a_reg      <= pos_a_next;
            pos_b_reg      <= pos_b_next;
            data_a_reg     <= data_a_next;
            data_b_reg     <= data_b_next;
            fin_valid_reg  <= fin_valid_next;
            fin_popped_reg <= fin_popped_next;
            fin_status_reg <= fin_status_next;
            fin_length_reg <= fin_length_next;
            out_valid_reg  <= out_valid_next;
            out_popped_reg <= out_popped_next;
            out_status_reg <= out_status_next;
            out_length_reg <= out_length_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{OUT_PAD{1'b0}}, out_length_reg, out_status_reg, out_popped_reg};

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("count above capacity");

    a_busy_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !fin_valid_reg)
        else $error("result slot occupied while a long request runs");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
        ((count_reg == $past(count_reg) + CNT_W'(1)) ||
         ($past(count_reg) == count_reg + CNT_W'(1))))
        else $error("count moved by more than one");

    a_full_length: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg == ST_FULL)) |-> (out_length_reg == LEN_W'(DEPTH)))
        else $error("full status without full length");
`endif

endmodule

### rtl/sortable_int_vector.sv
// top level: sequencer plus a row of entry cells linked as a ring
//
//  channel  | signals                          | content
//  ---------+----------------------------------+--------------------------------------------
//  request  | s_tvalid s_tready s_tuser s_tdata | tuser: cmd; tdata: value, index_a, index_b
//  result   | m_tvalid m_tready m_tdata         | tdata: popped, status, length
//
// push back, push front, pop front, failed and unused requests: finished in S_IDLE as they are taken
// pop back: one full turn of the cell ring past cell zero, in S_ROT
// swap: one turn in S_ROT to read both entries, then S_SWAP to write them
// sort: odd-even compare-exchange phases across the cell row, in S_SORT
// a result passes through the fin and out registers to m_tdata once done; one more request may be taken
// while it waits; entries are not cleared by reset, only the count and control state are
`timescale 1ns / 1ps

module sortable_int_vector (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [svec_pkg::IN_TDATA_W-1:0]     s_tdata,   // value[31:0], index_a[37:32], index_b[43:38]
    input  logic [svec_pkg::CMD_W-1:0]          s_tuser,   // cmd[2:0]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [svec_pkg::OUT_TDATA_W-1:0]    m_tdata    // popped[31:0], status[33:32], length[40:34]
);
    import svec_pkg::*;

    cell_ctrl_t        cctl;
    logic [DATA_W-1:0] entry_w [DEPTH];

    svec_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .head     (entry_w[0]),
        .cctl     (cctl)
    );

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_W-1:0] left_w;
        logic [DATA_W-1:0] right_w;

        // cell zero takes the pushed value on a front push; the top cell wraps to cell zero
        if (i == 0)
        begin : g_first
            assign left_w = cctl.value;
        end
        else
        begin : g_mid_l
            assign left_w = entry_w[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_w = entry_w[0];
        end
        else
        begin : g_mid_r
            assign right_w = entry_w[i+1];
        end

        svec_cell u_cell (
            .clk   (clk),
            .ctrl  (cctl),
            .idx   (IDX_W'(i)),
            .left  (left_w),
            .right (right_w),
            .entry (entry_w[i])
        );
    end

endmodule

### dv/svec_checker.sv
// request/result monitor with a behavioral vector model and in-order result compare
`timescale 1ns / 1ps

module svec_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [svec_pkg::IN_TDATA_W-1:0]  s_tdata,   // value[31:0], index_a[37:32], index_b[43:38]
    input  logic [svec_pkg::CMD_W-1:0]       s_tuser,   // cmd[2:0]
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [svec_pkg::OUT_TDATA_W-1:0] m_tdata,   // popped[31:0], status[33:32], length[40:34]
    output int                               errors,
    output int                               pending,
    output int                               held,
    output int                               results,
    output int                               full_cnt,
    output int                               empty_cnt,
    output int                               range_cnt,
    output int                               sort_cnt
);
    import svec_pkg::*;

    typedef struct {
        logic [DATA_W-1:0]   popped;
        logic [STATUS_W-1:0] status;
        logic [LEN_W-1:0]    length;
    } vec_result_t;

    vec_result_t               expected_q[$];
    logic signed [DATA_W-1:0]  vals[DEPTH];
    int                        held_n;
    int                        err_n;
    int                        res_n;
    int                        full_n;
    int                        empty_n;
    int                        range_n;
    int                        sort_n;

    task automatic apply_request(input logic [CMD_W-1:0] op, input logic signed [DATA_W-1:0] val,
                                 input logic [FIELD_IDX_W-1:0] ia,
                                 input logic [FIELD_IDX_W-1:0] ib, output vec_result_t r);
        logic signed [DATA_W-1:0] key;
        int i;
        int p;
        r.popped = '0;
        r.status = ST_OK;
        case (op)
            CMD_PUSH_BACK, CMD_PUSH_FRONT:
            begin
                if (held_n >= DEPTH)
                begin
                    r.status = ST_FULL;
                    full_n++;
                end
                else
                begin
                    if (op == CMD_PUSH_BACK)
                        vals[held_n] = val;
                    else
                    begin
                        for (i = held_n; i > 0; i--)
                            vals[i] = vals[i-1];
                        vals[0] = val;
                    end
                    held_n++;
                end
            end
            CMD_POP_BACK:
            begin
                if (held_n == 0)
                begin
                    r.status = ST_EMPTY;
                    empty_n++;
                end
                else
                begin
                    held_n--;
                    r.popped = vals[held_n];
                end
            end
            CMD_POP_FRONT:
            begin
                if (held_n == 0)
                begin
                    r.status = ST_EMPTY;
                    empty_n++;
                end
                else
                begin
                    r.popped = vals[0];
                    for (i = 1; i < held_n; i++)
                        vals[i-1] = vals[i];
                    held_n--;
                end
            end
            CMD_SWAP:
            begin
                if (int'(ia) >= held_n || int'(ib) >= held_n)
                begin
                    r.status = ST_RANGE;
                    range_n++;
                end
                else
                begin
                    key      = vals[ia];
                    vals[ia] = vals[ib];
                    vals[ib] = key;
                end
            end
            CMD_SORT:
            begin
                if (held_n > 1)
                    sort_n++;
                for (i = 1; i < held_n; i++)
                begin
                    key = vals[i];
                    p   = i;
                    while (p > 0 && vals[p-1] > key)
                    begin
                        vals[p] = vals[p-1];
                        p--;
                    end
                    vals[p] = key;
                end
            end
            default: ;
        endcase
        r.length = held_n[LEN_W-1:0];
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        vec_result_t want;
        vec_result_t got;
        if (!rst_n)
        begin
            expected_q.delete();
            held_n  = 0;
            err_n   = 0;
            res_n   = 0;
            full_n  = 0;
            empty_n = 0;
            range_n = 0;
            sort_n  = 0;
        end
        else
        begin
            // results never leave in the cycle their request is taken, so compare first
            if (m_tvalid && m_tready)
            begin
                got.popped = m_tdata[31:0];
                got.status = m_tdata[33:32];
                got.length = m_tdata[40:34];
                res_n++;
                if (expected_q.size() == 0)
                begin
                    err_n++;
                    $error("result with nothing outstanding: tdata %h", m_tdata);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.popped !== want.popped)
                    begin
                        err_n++;
                        $error("popped: expected %0d, actual %0d",
                               $signed(want.popped), $signed(got.popped));
                    end
                    if (got.status !== want.status)
                    begin
                        err_n++;
                        $error("status: expected %0d, actual %0d", want.status, got.status);
                    end
                    if (got.length !== want.length)
                    begin
                        err_n++;
                        $error("length: expected %0d, actual %0d", want.length, got.length);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                apply_request(s_tuser, s_tdata[31:0], s_tdata[37:32], s_tdata[43:38], want);
                expected_q.push_back(want);
            end
        end
        errors    <= err_n;
        pending   <= expected_q.size();
        held      <= held_n;
        results   <= res_n;
        full_cnt  <= full_n;
        empty_cnt <= empty_n;
        range_cnt <= range_n;
        sort_cnt  <= sort_n;
    end

endmodule

### dv/tb_sortable_int_vector.sv
// top-level bench: clock, reset, request stimulus, result back-pressure and verdict
`timescale 1ns / 1ps

module tb_sortable_int_vector;

    import svec_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;
    localparam int NUM_REQUESTS   = 1500;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic [DATA_W-1:0] INT_MIN = 32'h8000_0000;
    localparam logic [DATA_W-1:0] INT_MAX = 32'h7FFF_FFFF;

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;
    typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED, PH_SORT} phase_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic [CMD_W-1:0]       s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    int       errors;
    int       pending;
    int       held;
    int       results;
    int       full_cnt;
    int       empty_cnt;
    int       range_cnt;
    int       sort_cnt;
    int       sent;
    int       burst_left;
    int       quiet;
    bit       gaps_on;
    bit       hold_off_req;
    rx_mode_t rx_mode;

    sortable_int_vector uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    svec_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .errors    (errors),
        .pending   (pending),
        .held      (held),
        .results   (results),
        .full_cnt  (full_cnt),
        .empty_cnt (empty_cnt),
        .range_cnt (range_cnt),
        .sort_cnt  (sort_cnt)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic send_request(input logic [CMD_W-1:0] op, input logic [DATA_W-1:0] val,
                                input logic [FIELD_IDX_W-1:0] ia,
                                input logic [FIELD_IDX_W-1:0] ib);
        s_tuser  <= op;
        s_tdata  <= {{(IN_TDATA_W - DATA_W - 2 * FIELD_IDX_W){1'b0}}, ib, ia, val};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        sent++;
    endtask

    // bursts of back-to-back requests, separated by idle gaps while gaps_on is set
    task automatic pace();
        int gap;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(1, 30);
            if (gaps_on)
            begin
                gap = $urandom_range(1, 12);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    function automatic logic [DATA_W-1:0] pick_value(input bit narrow);
        int sel;
        sel = $urandom_range(0, 99);
        if (narrow)
            return DATA_W'($signed($urandom_range(0, 15)) - 8);
        if (sel < 5)
            return INT_MIN;
        if (sel < 10)
            return INT_MAX;
        if (sel < 20)
            return DATA_W'($signed($urandom_range(0, 7)) - 4);
        return $urandom;
    endfunction

    function automatic logic [FIELD_IDX_W-1:0] pick_index();
        if (held > 0 && $urandom_range(0, 99) < 75)
            return FIELD_IDX_W'($urandom_range(0, held - 1));
        return FIELD_IDX_W'($urandom_range(0, DEPTH - 1));
    endfunction

    function automatic logic [CMD_W-1:0] pick_cmd(input phase_t ph);
        int sel;
        sel = $urandom_range(0, 99);
        case (ph)
            PH_FILL:
                if (sel < 88)
                    return (sel < 44) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
            PH_DRAIN:
                if (sel < 88)
                    return (sel < 44) ? CMD_POP_BACK : CMD_POP_FRONT;
            PH_SORT:
                if (sel < 70)
                    return (sel < 25) ? CMD_SORT : CMD_SWAP;
            default: ;
        endcase
        sel = $urandom_range(0, 99);
        if (sel < 18) return CMD_PUSH_BACK;
        if (sel < 34) return CMD_PUSH_FRONT;
        if (sel < 50) return CMD_POP_BACK;
        if (sel < 65) return CMD_POP_FRONT;
        if (sel < 85) return CMD_SWAP;
        if (sel < 95) return CMD_SORT;
        return (sel < 97) ? CMD_SPARE_6 : CMD_SPARE_7;
    endfunction

    // result side back-pressure, with one long hold-off on request
    initial
    begin
        int tick;
        tick = 0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            tick++;
            if (hold_off_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
                m_tready <= 1'b1;
            end
            else
            begin
                case (rx_mode)
                    RX_ALWAYS: m_tready <= 1'b1;
                    RX_RANDOM: m_tready <= ($urandom_range(0, 99) < 60);
                    default:   m_tready <= ((tick % 11) < 6);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet <= 0;
        else if (quiet >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    initial
    begin
        phase_t           ph;
        int               phase_left;
        bit               hold_started;
        logic [CMD_W-1:0] op;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = CMD_PUSH_BACK;
        sent         = 0;
        burst_left   = 0;
        gaps_on      = 1'b1;
        hold_off_req = 1'b0;
        hold_started = 1'b0;
        rx_mode      = RX_RANDOM;
        ph           = PH_MIXED;
        phase_left   = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corner cases on an empty, then a tiny vector
        send_request(CMD_POP_BACK,   '0, '0, '0);                  pace();
        send_request(CMD_POP_FRONT,  '0, '0, '0);                  pace();
        send_request(CMD_SWAP,       '0, '0, '0);                  pace();
        send_request(CMD_SORT,       '0, '0, '0);                  pace();
        send_request(CMD_PUSH_BACK,  INT_MAX, '0, '0);             pace();
        send_request(CMD_SORT,       '0, '0, '0);                  pace();
        send_request(CMD_SWAP,       '0, 6'd0, 6'd0);              pace();
        send_request(CMD_PUSH_FRONT, INT_MIN, '0, '0);             pace();
        send_request(CMD_PUSH_BACK,  32'hFFFF_FFFF, '0, '0);       pace();
        send_request(CMD_PUSH_FRONT, '0, '0, '0);                  pace();
        send_request(CMD_PUSH_BACK,  32'h0000_0001, '1, '1);       pace();
        send_request(CMD_SWAP,       '0, 6'd0, 6'd4);              pace();
        send_request(CMD_SWAP,       '0, 6'd2, 6'd2);              pace();
        send_request(CMD_SWAP,       '0, 6'd3, 6'd5);              pace();
        send_request(CMD_SWAP,       '0, 6'd63, 6'd0);             pace();
        send_request(CMD_SWAP,       '0, 6'd1, 6'd63);             pace();
        send_request(CMD_SORT,       '0, '0, '0);                  pace();
        send_request(CMD_SPARE_6,    32'hDEAD_BEEF, '1, '1);       pace();
        send_request(CMD_SPARE_7,    '1, '1, '1);                  pace();
        send_request(CMD_POP_FRONT,  '0, '0, '0);                  pace();
        send_request(CMD_POP_BACK,   '0, '0, '0);                  pace();
        send_request(CMD_PUSH_FRONT, INT_MAX, '0, '0);             pace();
        send_request(CMD_SORT,       '0, '0, '0);                  pace();
        send_request(CMD_POP_BACK,   '0, '0, '0);                  pace();

        while (sent < NUM_REQUESTS)
        begin
            if (phase_left == 0)
            begin
                ph         = phase_t'($urandom_range(0, 3));
                phase_left = (ph == PH_FILL || ph == PH_DRAIN) ? $urandom_range(60, 110)
                                                               : $urandom_range(20, 80);
                rx_mode    = rx_mode_t'($urandom_range(0, 2));
                gaps_on    = ($urandom_range(0, 99) < 65);
            end
            phase_left--;
            if (!hold_started && sent >= 400)
            begin
                hold_started = 1'b1;
                hold_off_req = 1'b1;
            end
            op = pick_cmd(ph);
            send_request(op, pick_value(ph == PH_SORT), pick_index(), pick_index());
            pace();
        end
        s_tvalid <= 1'b0;
        rx_mode = RX_ALWAYS;

        // let the checker count the last request before waiting on it
        repeat (2) @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (2 * DEPTH + 8) @(posedge clk);

        $display("sent %0d requests, checked %0d results", sent, results);
        $display("rejected pushes %0d, empty pops %0d, bad swaps %0d, sorts of two or more %0d",
                 full_cnt, empty_cnt, range_cnt, sort_cnt);
        if (errors == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
